[src/arxbc_pkg.sv]
// Shared types, widths and register indexes for the ARX block cipher encrypt unit.
// No dependencies; every other source file imports this package.
package arxbc_pkg;

   localparam int NUM_ROUNDS  = 10;
   localparam int HALF_W      = 16;
   localparam int STATE_W     = 2 * HALF_W;
   localparam int KEY_W       = HALF_W;
   localparam int ROT_W       = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   typedef logic [HALF_W-1:0]  half_type;
   typedef logic [STATE_W-1:0] state_type;
   typedef logic [NUM_ROUNDS-1:0][KEY_W-1:0] key_vec_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEYS_1_4  = 2'd0,
      CSR_KEYS_5_8  = 2'd1,
      CSR_KEYS_9_10 = 2'd2
   } csr_index_type;

   // Rotate a half left by the low bits of the amount.
   function automatic half_type rotl_half(input half_type x, input logic [ROT_W-1:0] s);
      logic [2*HALF_W-1:0] dbl;
      begin
         dbl = {x, x} << s;
         return dbl[2*HALF_W-1:HALF_W];
      end
   endfunction

endpackage

[src/arxbc_key_regs.sv]
// Round key configuration registers of the ARX block cipher encrypt unit.
// Depends on arxbc_pkg for widths and register indexes.
module arxbc_key_regs import arxbc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output key_vec_type            round_keys
);

   logic [4*KEY_W-1:0] keys_1_4_ff;
   logic [4*KEY_W-1:0] keys_5_8_ff;
   logic [2*KEY_W-1:0] keys_9_10_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_1_4_ff  <= '0;
         keys_5_8_ff  <= '0;
         keys_9_10_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEYS_1_4:  keys_1_4_ff  <= csr_data[4*KEY_W-1:0];
            CSR_KEYS_5_8:  keys_5_8_ff  <= csr_data[4*KEY_W-1:0];
            CSR_KEYS_9_10: keys_9_10_ff <= csr_data[2*KEY_W-1:0];
            default: ;
         endcase
      end
   end

   // Key of round one lands in element zero.
   assign round_keys = {keys_9_10_ff, keys_5_8_ff, keys_1_4_ff};

endmodule

[src/arxbc_round.sv]
// One registered cipher round: xor, data-dependent rotate and key mixing.
// Depends on arxbc_pkg for types and the rotate function.
module arxbc_round import arxbc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  state_type        in_state,
   input  logic [KEY_W-1:0] key,
   input  logic             final_round,
   output logic             out_valid,
   output state_type        out_state
);

   logic      valid_ff;
   state_type state_ff;
   state_type state_in;
   half_type  left;
   half_type  right;
   half_type  new_right;
   half_type  rotated;
   half_type  new_left;

   always_comb begin
      left      = in_state[STATE_W-1:HALF_W];
      right     = in_state[HALF_W-1:0];
      new_right = right ^ left;
      rotated   = rotl_half(left, new_right[ROT_W-1:0]);
      // The last round adds the key instead of xoring it.
      new_left  = final_round ? half_type'(rotated + key) : (rotated ^ key);
      state_in  = {new_right, new_left};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

[src/arx_block_cipher_encrypt_unit.sv]
// Top level of the ARX block cipher encrypt unit: ten pipelined rounds plus alignment.
// Depends on arxbc_pkg, arxbc_key_regs and arxbc_round.
//
//   Channel   | Handshake                 | Payload
//   ----------+---------------------------+------------------------------------------
//   request   | req_start, busy           | req_plain_left, req_plain_right
//   response  | rsp_strobe (no backpress) | rsp_after_round_one .. rsp_ciphertext
//   config    | csr_write                 | csr_index, csr_data
//
// Every item passes through one register stage per round from acceptance to its result
// strobe, and a new item is accepted in every cycle, so ten items can be in flight.
// The unit never stalls: busy stays low and the receiver cannot hold results off.
// A synchronous reset clears the valid bits of all stages and sets all round keys to zero.
// The states after rounds one to nine leave through delay lines so that all nine appear together
// with the ciphertext in the same strobe cycle.
module arx_block_cipher_encrypt_unit import arxbc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   output logic                   busy,
   input  logic [HALF_W-1:0]      req_plain_left,
   input  logic [HALF_W-1:0]      req_plain_right,
   output logic                   rsp_strobe,
   output logic [STATE_W-1:0]     rsp_after_round_one,
   output logic [STATE_W-1:0]     rsp_after_round_two,
   output logic [STATE_W-1:0]     rsp_after_round_three,
   output logic [STATE_W-1:0]     rsp_after_round_four,
   output logic [STATE_W-1:0]     rsp_after_round_five,
   output logic [STATE_W-1:0]     rsp_after_round_six,
   output logic [STATE_W-1:0]     rsp_after_round_seven,
   output logic [STATE_W-1:0]     rsp_after_round_eight,
   output logic [STATE_W-1:0]     rsp_after_round_nine,
   output logic [STATE_W-1:0]     rsp_ciphertext,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   key_vec_type round_keys;
   logic        stage_valid [NUM_ROUNDS];
   state_type   stage_state [NUM_ROUNDS];
   state_type   aligned     [NUM_ROUNDS];
   logic        accept;

   // The pipeline takes an item in every cycle, so it never reports busy.
   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   arxbc_key_regs u_key_regs (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .round_keys (round_keys)
   );

   // One register stage per round. Stage zero takes the plaintext halves.
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      if (r == 0) begin : g_first
         arxbc_round u_round (
            .clock       (clock),
            .reset       (reset),
            .in_valid    (accept),
            .in_state    ({req_plain_left, req_plain_right}),
            .key         (round_keys[r]),
            .final_round (1'b0),
            .out_valid   (stage_valid[r]),
            .out_state   (stage_state[r])
         );
      end else begin : g_next
         arxbc_round u_round (
            .clock       (clock),
            .reset       (reset),
            .in_valid    (stage_valid[r-1]),
            .in_state    (stage_state[r-1]),
            .key         (round_keys[r]),
            .final_round (r == NUM_ROUNDS - 1),
            .out_valid   (stage_valid[r]),
            .out_state   (stage_state[r])
         );
      end
   end

   // Each intermediate state waits in a delay line until the item reaches the
   // last stage; the line for round r holds the state for the remaining rounds.
   for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_align
      if (j == NUM_ROUNDS - 1) begin : g_direct
         assign aligned[j] = stage_state[j];
      end else begin : g_delay
         localparam int DEPTH = NUM_ROUNDS - 1 - j;
         state_type dly_ff [DEPTH];

         always_ff @(posedge clock) begin
            dly_ff[0] <= stage_state[j];
            for (int t = 1; t < DEPTH; t++) begin
               dly_ff[t] <= dly_ff[t-1];
            end
         end

         assign aligned[j] = dly_ff[DEPTH-1];
      end
   end

   assign rsp_strobe            = stage_valid[NUM_ROUNDS-1];
   assign rsp_after_round_one   = aligned[0];
   assign rsp_after_round_two   = aligned[1];
   assign rsp_after_round_three = aligned[2];
   assign rsp_after_round_four  = aligned[3];
   assign rsp_after_round_five  = aligned[4];
   assign rsp_after_round_six   = aligned[5];
   assign rsp_after_round_seven = aligned[6];
   assign rsp_after_round_eight = aligned[7];
   assign rsp_after_round_nine  = aligned[8];
   assign rsp_ciphertext        = aligned[9];

   // A result strobe always traces back to an accepted item.
   a_strobe_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, NUM_ROUNDS))
      else $error("result strobe without a matching accepted item");

   // The first half after round one is the xor of the plaintext halves.
   a_round_one_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_after_round_one[STATE_W-1:HALF_W] ==
                      $past(req_plain_left ^ req_plain_right, NUM_ROUNDS)))
      else $error("round one state is misaligned with its item");

   // The ciphertext's first half is the xor of the halves after round nine.
   a_last_round_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_ciphertext[STATE_W-1:HALF_W] ==
                      (rsp_after_round_nine[STATE_W-1:HALF_W] ^
                       rsp_after_round_nine[HALF_W-1:0])))
      else $error("ciphertext does not follow from the round nine state");

endmodule
